[src/otw_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the three-wheel odometry block.
// Used by every module under src; depends on nothing.
package otw_pkg;

  // fixed-point constants
  localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
  localparam logic [30:0] GYRO_Q40 = 31'd1919009807;
  localparam logic [32:0] TWO_PI_U = 33'd6746518852;
  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] TWO_PI_Q30 = 34'sd6746518852;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int CORDIC_STEPS = 30;
  localparam int RED_STEPS = 8;
  localparam int DIV_STEPS = 33;

  // register reset values
  localparam logic [31:0] RST_TRK_RADIUS = 32'd23228148;
  localparam logic [31:0] RST_SIDE_OFFSET = 32'd73950573;
  localparam logic [31:0] RST_BACK_OFFSET = 32'd50331648;
  localparam logic [30:0] RST_GYRO_THRESHOLD = 31'd292818;
  localparam logic signed [31:0] RST_START_HEADING = 32'sd0;

  // configuration register indexes
  localparam logic [2:0] CFG_TRK_RADIUS = 3'd0;
  localparam logic [2:0] CFG_SIDE_OFFSET = 3'd1;
  localparam logic [2:0] CFG_BACK_OFFSET = 3'd2;
  localparam logic [2:0] CFG_GYRO_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_START_HEADING = 3'd4;

  // wheel selector codes
  localparam logic [1:0] WHEEL_LEFT = 2'd0;
  localparam logic [1:0] WHEEL_RIGHT = 2'd1;
  localparam logic [1:0] WHEEL_BACK = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE, ST_TR_A, ST_TR_B, ST_TR_C, ST_TR_D, ST_GY_A, ST_GY_B,
    ST_OD_GO, ST_OD_WAIT, ST_OD_END, ST_HD_A, ST_HD_B, ST_HD_C, ST_HD_D,
    ST_SC_GO, ST_SC_WAIT, ST_SC_END, ST_CH_A, ST_CH_B, ST_CH_C, ST_CH_WAIT,
    ST_CH_END, ST_RC_GO, ST_RC_WAIT, ST_RC_END, ST_RT_A, ST_RT_B, ST_RT_C,
    ST_RT_D, ST_RT_E, ST_RT_F, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    COR_IDLE, COR_RED, COR_FOLD1, COR_FOLD2, COR_ITER
  } cor_ph_t;

  typedef struct packed {
    state_t op;
    logic [1:0] wheel;
    logic chord;
    logic take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic cor_busy;
    logic c_zero;
  } status_t;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7fffffff;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // sign and magnitude to signed 32, magnitude clamped to 2^31-1
  function automatic logic signed [31:0] smag32(input logic neg, input logic [47:0] q);
    logic [30:0] m;
    logic signed [31:0] r;
    m = (q > 48'd2147483647) ? 31'h7fffffff : q[30:0];
    r = $signed({1'b0, m});
    return neg ? -r : r;
  endfunction

  // arctangent of 2^-i in Q2.30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sh03243F6A8;
      5'd1: r = 34'sh01DAC6705;
      5'd2: r = 34'sh00FADBAFC;
      5'd3: r = 34'sh007F56EA6;
      5'd4: r = 34'sh003FEAB76;
      5'd5: r = 34'sh001FFD55B;
      5'd6: r = 34'sh000FFFAAA;
      5'd7: r = 34'sh0007FFF55;
      5'd8: r = 34'sh0003FFFEA;
      5'd9: r = 34'sh0001FFFFD;
      5'd10: r = 34'sh0000FFFFF;
      default: r = 34'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

[src/three_wheel_odometry_update.sv]
`timescale 1ns / 1ps
// Three tracking-wheel arc odometry, one pose update per input word.
//
// Input stream s_axis: one word holds left, right and back encoder readings in
// degrees and the accumulated gyro heading in tenths of a degree. Each word
// produces exactly one output word on m_axis: x and y in Q16.16 inches and the
// heading in Q8.24 radians, after the update.
// The configuration port writes one register per cycle (cfg_we, cfg_index,
// cfg_data); write only while no update is in flight.
// Throughput: one word at a time. The update time is set by the serial divider
// (one run, plus two more for the arc chord) and the iterative CORDIC (one or two
// runs), with a shared 33x33 multiplier.
// s_axis_tready is high only while the block waits for a word.
// The result sits in an output register; the next word is taken while it waits,
// and the block holds at the end of that next update until m_axis_tready frees it.
// Reset (synchronous, rst high) restores all registers to defaults, the heading
// to the start heading and the position and last readings to zero.
module three_wheel_odometry_update (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // left_count, right_count, back_count, gyro_tenths
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // pos_x, pos_y, heading
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import otw_pkg::*;

  cmd_t cmd;
  status_t status;
  logic signed [31:0] pos_x, pos_y, heading;

  otw_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .status(status), .cmd(cmd)
  );

  otw_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .left_count($signed(s_axis_tdata[23:0])),
    .right_count($signed(s_axis_tdata[47:24])),
    .back_count($signed(s_axis_tdata[71:48])),
    .gyro_tenths($signed(s_axis_tdata[95:72])),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading)
  );

  assign m_axis_tdata = {heading, pos_y, pos_x};

  // one word in flight at a time
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an update is in flight");

  // arithmetic units are quiet while waiting for a word
  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !status.div_busy && !status.cor_busy)
    else $error("divider or cordic busy while idle");

  // a result appears only at the end of an update
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised without an update");

endmodule

[src/otw_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 33-bit quotient with overflow flag.
// Depends on otw_pkg.
module otw_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] num,
  input  logic [38:0] den,
  output logic        busy,
  output logic [32:0] quo,
  output logic        ovf
);
  import otw_pkg::*;

  logic [39:0] rem;
  logic [32:0] nlow;
  logic [38:0] den_r;
  logic [5:0]  cnt;
  logic [39:0] trial;

  // next partial remainder
  assign trial = {rem[38:0], nlow[32]};
  assign busy = (cnt != 6'd0);

  // control counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else if (go) begin
      cnt <= 6'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 6'd1;
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (go) begin
      ovf <= {9'd0, num[63:33]} >= {1'b0, den};
      rem <= {9'd0, num[63:33]};
      nlow <= num[32:0];
      den_r <= den;
      quo <= 33'd0;
    end else if (busy) begin
      nlow <= {nlow[31:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem <= trial - {1'b0, den_r};
        quo <= {quo[31:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[31:0], 1'b0};
      end
    end
  end

endmodule

[src/otw_cordic.sv]
`timescale 1ns / 1ps
// Iterative sine/cosine unit: range reduction mod 2*pi, quadrant fold, 30 rotations.
// Depends on otw_pkg.
module otw_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [33:0] ang,
  output logic               busy,
  output logic signed [33:0] sin_v,
  output logic signed [33:0] cos_v
);
  import otw_pkg::*;

  cor_ph_t ph;
  logic [39:0] zmag;
  logic zneg;
  logic [2:0] red_k;
  logic [4:0] it;
  logic signed [33:0] z, x, y;
  logic neg;
  logic [39:0] red_cmp;
  logic signed [33:0] r0;
  logic signed [39:0] zf;

  assign zf = {ang, 6'd0};
  assign red_cmp = 40'(TWO_PI_U) << red_k;
  assign r0 = zneg ? -$signed({1'b0, zmag[32:0]}) : $signed({1'b0, zmag[32:0]});
  assign busy = (ph != COR_IDLE);
  assign sin_v = y;
  assign cos_v = neg ? -x : x;

  // phase sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= COR_IDLE;
    end else begin
      case (ph)
        COR_IDLE: if (go) ph <= COR_RED;
        COR_RED: if (red_k == 3'd0) ph <= COR_FOLD1;
        COR_FOLD1: ph <= COR_FOLD2;
        COR_FOLD2: ph <= COR_ITER;
        COR_ITER: if (it == 5'(CORDIC_STEPS - 1)) ph <= COR_IDLE;
        default: ph <= COR_IDLE;
      endcase
    end
  end

  // angle reduction and rotations
  always_ff @(posedge clk) begin
    case (ph)
      COR_IDLE: begin
        if (go) begin
          zneg <= ang[33];
          zmag <= ang[33] ? (~zf + 40'd1) : zf;
          red_k <= 3'(RED_STEPS - 1);
        end
      end
      COR_RED: begin
        if (zmag >= red_cmp) zmag <= zmag - red_cmp;
        red_k <= red_k - 3'd1;
      end
      COR_FOLD1: begin
        if (r0 > PI_Q30) z <= r0 - TWO_PI_Q30;
        else if (r0 < -PI_Q30) z <= r0 + TWO_PI_Q30;
        else z <= r0;
      end
      COR_FOLD2: begin
        x <= CORDIC_GAIN;
        y <= 34'sd0;
        it <= 5'd0;
        if (z > HALF_PI_Q30) begin
          z <= PI_Q30 - z;
          neg <= 1'b1;
        end else if (z < -HALF_PI_Q30) begin
          z <= -PI_Q30 - z;
          neg <= 1'b1;
        end else begin
          neg <= 1'b0;
        end
      end
      COR_ITER: begin
        it <= it + 5'd1;
        if (!z[33]) begin
          x <= x - (y >>> it);
          y <= y + (x >>> it);
          z <= z - atan_q30(it);
        end else begin
          x <= x + (y >>> it);
          y <= y - (x >>> it);
          z <= z + atan_q30(it);
        end
      end
      default: ;
    endcase
  end

endmodule

[src/otw_dp.sv]
`timescale 1ns / 1ps
// Odometry datapath: configuration registers, pose state, shared multiplier,
// divider and CORDIC units. Depends on otw_pkg, otw_div, otw_cordic.
module otw_dp (
  input  logic               clk,
  input  logic               rst,
  input  otw_pkg::cmd_t      cmd,
  output otw_pkg::status_t   status,
  input  logic signed [23:0] left_count,
  input  logic signed [23:0] right_count,
  input  logic signed [23:0] back_count,
  input  logic signed [23:0] gyro_tenths,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] heading
);
  import otw_pkg::*;

  logic [31:0] trk_radius, side_wheel_offset, back_wheel_offset;
  logic [30:0] gyro_switch_threshold;
  logic signed [31:0] start_heading;
  logic signed [23:0] cnt_l, cnt_r, cnt_b, cnt_g;
  logic signed [31:0] heading_reg, x_reg, y_reg;
  logic signed [31:0] last_gyro_angle, last_right_travel, last_back_travel;
  logic signed [31:0] lt, rt, bt, g, odom, nh, db, dr, lx, ly;
  logic signed [32:0] diff, gd, c, half_c, sa, ca;
  logic d_ge, use_gyro, s_neg;
  logic [31:0] s_mag;
  logic [27:0] t_lo;
  logic signed [27:0] t2;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [66:0] acc;

  logic signed [23:0] cnt_sel;
  logic [23:0] cnt_mag, gyro_mag;
  logic signed [31:0] d_sel;
  logic [31:0] d_mag, off_sel;
  logic [32:0] c_mag, diff_mag, dg_mag;
  logic signed [32:0] dg;
  logic [55:0] tr_b;
  logic [56:0] tr_sum;
  logic [54:0] gy_sum;
  logic [64:0] t2_sum;
  logic [26:0] t2m;
  logic t1neg;
  logic [33:0] t1m;
  logic signed [35:0] t1, ch_sum;
  logic signed [36:0] gxr;
  logic signed [31:0] delta;

  logic div_go, div_busy, div_ovf;
  logic [63:0] div_num;
  logic [38:0] div_den;
  logic [32:0] div_quo;
  logic cor_go, cor_busy;
  logic signed [33:0] cor_ang, cor_sin, cor_cos;

  otw_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_quo), .ovf(div_ovf)
  );

  otw_cordic u_cordic (
    .clk(clk), .rst(rst), .go(cor_go), .ang(cor_ang),
    .busy(cor_busy), .sin_v(cor_sin), .cos_v(cor_cos)
  );

  // operand selection and magnitudes
  always_comb begin
    case (cmd.wheel)
      WHEEL_LEFT: cnt_sel = cnt_l;
      WHEEL_RIGHT: cnt_sel = cnt_r;
      default: cnt_sel = cnt_b;
    endcase
  end

  assign cnt_mag = cnt_sel[23] ? (~cnt_sel + 24'd1) : cnt_sel;
  assign gyro_mag = cnt_g[23] ? (~cnt_g + 24'd1) : cnt_g;
  assign d_sel = cmd.chord ? dr : db;
  assign d_mag = d_sel[31] ? (~d_sel + 32'd1) : d_sel;
  assign off_sel = cmd.chord ? side_wheel_offset : back_wheel_offset;
  assign c_mag = c[32] ? (~c + 33'd1) : c;
  assign diff_mag = diff[32] ? (~diff + 33'd1) : diff;
  assign dg = 33'(g) - 33'(odom);
  assign dg_mag = dg[32] ? (~dg + 33'd1) : dg;

  // rounding of products
  assign tr_b = prod[55:0] + (56'd1 << 39);
  assign tr_sum = 57'(acc[55:0]) + 57'(tr_b[55:28]);
  assign gy_sum = prod[54:0] + 55'd32768;
  assign t2_sum = {1'b0, prod[63:0]} + (65'd1 << 37);
  assign t2m = t2_sum[64:38];

  // chord quotient term
  assign t1neg = s_neg ^ d_sel[31] ^ c[32];
  assign t1m = div_ovf ? 34'h200000000 : {1'b0, div_quo};
  assign t1 = t1neg ? -$signed({2'b0, t1m}) : $signed({2'b0, t1m});
  assign ch_sum = t1 + 36'(t2);

  // rounded rotation sum
  assign gxr = 37'((acc + 67'sd536870912) >>> 30);

  // wheel heading change
  always_comb begin
    if (diff == 33'sd0) delta = 32'sd0;
    else if (d_ge) delta = smag32(diff[32], 48'h7fffffff);
    else delta = smag32(diff[32], 48'(div_quo));
  end

  // shared multiplier operands
  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    case (cmd.op)
      ST_TR_A: begin
        mul_a = $signed({9'd0, cnt_mag});
        mul_b = $signed({1'b0, trk_radius});
      end
      ST_TR_B: begin
        mul_a = $signed({5'd0, prod[55:28]});
        mul_b = $signed({6'd0, DEG2RAD_Q32});
      end
      ST_TR_C: begin
        mul_a = $signed({5'd0, t_lo});
        mul_b = $signed({6'd0, DEG2RAD_Q32});
      end
      ST_GY_A: begin
        mul_a = $signed({9'd0, gyro_mag});
        mul_b = $signed({2'd0, GYRO_Q40});
      end
      ST_CH_A: begin
        mul_a = $signed({1'b0, s_mag});
        mul_b = $signed({1'b0, d_mag});
      end
      ST_CH_B: begin
        mul_a = $signed({1'b0, s_mag});
        mul_b = $signed({1'b0, off_sel});
      end
      ST_RT_A: begin
        mul_a = 33'(lx);
        mul_b = ca;
      end
      ST_RT_B: begin
        mul_a = 33'(ly);
        mul_b = sa;
      end
      ST_RT_C: begin
        mul_a = 33'(ly);
        mul_b = ca;
      end
      ST_RT_D: begin
        mul_a = 33'(lx);
        mul_b = sa;
      end
      default: ;
    endcase
  end

  // divider and cordic launch
  assign div_go = (cmd.op == ST_OD_GO) || (cmd.op == ST_CH_B);
  assign div_num = (cmd.op == ST_OD_GO) ?
                   ({diff_mag[31:0], 32'd0} >> 1) + 64'(side_wheel_offset >> 1) :
                   prod[63:0];
  assign div_den = (cmd.op == ST_OD_GO) ? 39'(side_wheel_offset) : {c_mag, 6'd0};
  assign cor_go = (cmd.op == ST_SC_GO) || (cmd.op == ST_RC_GO);
  assign cor_ang = (cmd.op == ST_SC_GO) ? 34'(half_c) : 34'(heading_reg) + 34'(half_c);

  assign status.div_busy = div_busy;
  assign status.cor_busy = cor_busy;
  assign status.c_zero = (c == 33'sd0);

  // multiplier output register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trk_radius <= RST_TRK_RADIUS;
      side_wheel_offset <= RST_SIDE_OFFSET;
      back_wheel_offset <= RST_BACK_OFFSET;
      gyro_switch_threshold <= RST_GYRO_THRESHOLD;
      start_heading <= RST_START_HEADING;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRK_RADIUS: trk_radius <= cfg_data;
        CFG_SIDE_OFFSET: side_wheel_offset <= cfg_data;
        CFG_BACK_OFFSET: back_wheel_offset <= cfg_data;
        CFG_GYRO_THRESHOLD: gyro_switch_threshold <= cfg_data[30:0];
        CFG_START_HEADING: start_heading <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_reg <= RST_START_HEADING;
      x_reg <= 32'sd0;
      y_reg <= 32'sd0;
      last_gyro_angle <= 32'sd0;
      last_right_travel <= 32'sd0;
      last_back_travel <= 32'sd0;
    end else begin
      case (cmd.op)
        ST_RT_D: x_reg <= sat32(68'(x_reg) + 68'(gxr));
        ST_RT_F: begin
          y_reg <= sat32(68'(y_reg) + 68'(gxr));
          heading_reg <= nh;
          last_gyro_angle <= g;
          last_right_travel <= rt;
          last_back_travel <= bt;
        end
        default: ;
      endcase
    end
  end

  // working registers of one update
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cnt_l <= left_count;
      cnt_r <= right_count;
      cnt_b <= back_count;
      cnt_g <= gyro_tenths;
    end
    case (cmd.op)
      ST_TR_B: t_lo <= prod[27:0];
      ST_TR_C: acc <= 67'(prod);
      ST_TR_D: begin
        case (cmd.wheel)
          WHEEL_LEFT: lt <= smag32(cnt_sel[23], 48'(tr_sum[56:12]));
          WHEEL_RIGHT: rt <= smag32(cnt_sel[23], 48'(tr_sum[56:12]));
          default: bt <= smag32(cnt_sel[23], 48'(tr_sum[56:12]));
        endcase
      end
      ST_GY_B: begin
        g <= smag32(cnt_g[23], 48'(gy_sum[54:16]));
        diff <= 33'(lt) - 33'(rt);
      end
      ST_OD_GO: d_ge <= diff_mag >= {1'b0, side_wheel_offset};
      ST_OD_END: odom <= sat32(68'(start_heading) + 68'(delta));
      ST_HD_A: begin
        use_gyro <= dg_mag > {2'b0, gyro_switch_threshold};
        gd <= 33'(g) - 33'(last_gyro_angle);
      end
      ST_HD_B: begin
        nh <= use_gyro ? sat32(68'(heading_reg) + 68'(gd)) : odom;
        db <= sat32(68'(bt) - 68'(last_back_travel));
        dr <= sat32(68'(rt) - 68'(last_right_travel));
      end
      ST_HD_C: c <= 33'(nh) - 33'(heading_reg);
      ST_HD_D: begin
        half_c <= c[32] ? ((c + 33'sd1) >>> 1) : (c >>> 1);
        lx <= db;
        ly <= dr;
      end
      ST_SC_END: begin
        s_neg <= cor_sin[33];
        s_mag <= cor_sin[33] ? 32'((~cor_sin + 34'sd1) << 1) : 32'(cor_sin << 1);
      end
      ST_CH_C: t2 <= s_neg ? -$signed({1'b0, t2m}) : $signed({1'b0, t2m});
      ST_CH_END: begin
        if (cmd.chord) ly <= sat32(68'(ch_sum));
        else lx <= sat32(68'(ch_sum));
      end
      ST_RC_END: begin
        sa <= cor_sin[32:0];
        ca <= cor_cos[32:0];
      end
      ST_RT_B: acc <= 67'(prod);
      ST_RT_C: acc <= acc + 67'(prod);
      ST_RT_D: acc <= 67'(prod);
      ST_RT_E: acc <= acc - 67'(prod);
      default: ;
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pos_x <= x_reg;
      pos_y <= y_reg;
      heading <= heading_reg;
    end
  end

endmodule

[src/otw_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for one odometry update: steps the datapath and runs the handshakes.
// Depends on otw_pkg.
module otw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_valid,
  output logic             s_ready,
  output logic             m_valid,
  input  logic             m_ready,
  input  otw_pkg::status_t status,
  output otw_pkg::cmd_t    cmd
);
  import otw_pkg::*;

  state_t state, state_next;
  logic [1:0] wheel;
  logic chord;

  // state register, wheel and chord counters, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wheel <= WHEEL_LEFT;
      chord <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.take) wheel <= WHEEL_LEFT;
      else if (state == ST_TR_D) wheel <= wheel + 2'd1;
      if (state == ST_HD_D) chord <= 1'b0;
      else if (state == ST_CH_END) chord <= 1'b1;
      if (cmd.out_load) m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_valid) state_next = ST_TR_A;
      ST_TR_A: state_next = ST_TR_B;
      ST_TR_B: state_next = ST_TR_C;
      ST_TR_C: state_next = ST_TR_D;
      ST_TR_D: state_next = (wheel == WHEEL_BACK) ? ST_GY_A : ST_TR_A;
      ST_GY_A: state_next = ST_GY_B;
      ST_GY_B: state_next = ST_OD_GO;
      ST_OD_GO: state_next = ST_OD_WAIT;
      ST_OD_WAIT: if (!status.div_busy) state_next = ST_OD_END;
      ST_OD_END: state_next = ST_HD_A;
      ST_HD_A: state_next = ST_HD_B;
      ST_HD_B: state_next = ST_HD_C;
      ST_HD_C: state_next = ST_HD_D;
      ST_HD_D: state_next = status.c_zero ? ST_RC_GO : ST_SC_GO;
      ST_SC_GO: state_next = ST_SC_WAIT;
      ST_SC_WAIT: if (!status.cor_busy) state_next = ST_SC_END;
      ST_SC_END: state_next = ST_CH_A;
      ST_CH_A: state_next = ST_CH_B;
      ST_CH_B: state_next = ST_CH_C;
      ST_CH_C: state_next = ST_CH_WAIT;
      ST_CH_WAIT: if (!status.div_busy) state_next = ST_CH_END;
      ST_CH_END: state_next = chord ? ST_RC_GO : ST_CH_A;
      ST_RC_GO: state_next = ST_RC_WAIT;
      ST_RC_WAIT: if (!status.cor_busy) state_next = ST_RC_END;
      ST_RC_END: state_next = ST_RT_A;
      ST_RT_A: state_next = ST_RT_B;
      ST_RT_B: state_next = ST_RT_C;
      ST_RT_C: state_next = ST_RT_D;
      ST_RT_D: state_next = ST_RT_E;
      ST_RT_E: state_next = ST_RT_F;
      ST_RT_F: state_next = ST_OUT;
      ST_OUT: if (!m_valid || m_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    s_ready = (state == ST_IDLE);
    cmd.op = state;
    cmd.wheel = wheel;
    cmd.chord = chord;
    cmd.take = (state == ST_IDLE) && s_valid;
    cmd.out_load = (state == ST_OUT) && (!m_valid || m_ready);
  end

endmodule

[tb/three_wheel_odometry_update_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for three_wheel_odometry_update: stream stimulus, own pose predictor.
// Depends on src/otw_pkg.sv and src/three_wheel_odometry_update.sv.
module three_wheel_odometry_update_test;
  import otw_pkg::*;

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam longint ATAN_STEP [11] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF
  };
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
  } pose_t;

  typedef struct {
    longint left, right, back, gyro;
    bit     typed;
    pose_t  pose;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // left_count, right_count, back_count, gyro_tenths
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;        // pos_x, pos_y, heading
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  three_wheel_odometry_update uut (.*);

  always #10 clk = ~clk;

  // predictor copy of configuration and state
  longint unsigned radius_q, side_q, back_q, thresh_q;
  longint start_hdg;
  longint hdg, px, py, prev_gyro, prev_right, prev_back;

  pose_t pending_poses [$];
  int    fails = 0;
  int    send_idle = 0;
  int    recv_stall = 0;
  bit    hold_req = 1'b0;
  int    hold_left = 0;
  longint walk_l, walk_r, walk_b;

  function automatic longint clamp32(longint v);
    return v > S32_HI ? S32_HI : (v < S32_LO ? S32_LO : v);
  endfunction

  function automatic longint from_mag(bit neg, longint unsigned q);
    longint r;
    if (q > 64'd2147483647) q = 64'd2147483647;
    r = longint'(q);
    return neg ? -r : r;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint wheel_travel(longint cnt);
    longint unsigned m, t, a, b, q;
    m = longint'(abs64(cnt));
    t = m * radius_q;
    a = (t >> 28) * 64'd74961321;
    b = (t & ((64'd1 << 28) - 1)) * 64'd74961321;
    q = (a + ((b + (64'd1 << 39)) >> 28)) >> 12;
    return from_mag(cnt < 0, q);
  endfunction

  function automatic longint gyro_angle(longint cnt);
    longint unsigned m;
    m = longint'(abs64(cnt));
    return from_mag(cnt < 0, (m * 64'd1919009807 + (64'd1 << 15)) >> 16);
  endfunction

  function automatic longint wheel_turn(longint diff);
    longint unsigned m;
    if (diff == 0) return 0;
    m = longint'(abs64(diff));
    if (m >= side_q) return from_mag(diff < 0, 64'd2147483647);
    return from_mag(diff < 0, ((m << 31) + side_q / 2) / side_q);
  endfunction

  // 30-step rotation, angle in Q8.24, results in Q2.30
  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint z, x, y, at, dx, dy, two_pi, pi_v, half_pi;
    bit neg;
    two_pi = longint'(TWO_PI_Q30);
    pi_v = longint'(PI_Q30);
    half_pi = longint'(HALF_PI_Q30);
    z = ang * 64;
    x = longint'(CORDIC_GAIN);
    y = 0;
    neg = 1'b0;
    z = z - (z / two_pi) * two_pi;
    if (z > pi_v) z = z - two_pi;
    else if (z < -pi_v) z = z + two_pi;
    if (z > half_pi) begin
      z = pi_v - z;
      neg = 1'b1;
    end else if (z < -half_pi) begin
      z = -pi_v - z;
      neg = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      at = i < 11 ? ATAN_STEP[i] : (64'sd1 <<< (30 - i));
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - at;
      end else begin
        x = x + dx; y = y - dy; z = z + at;
      end
    end
    s = y;
    c = neg ? -x : x;
  endfunction

  function automatic longint arc_chord(longint s, longint d, longint c, longint unsigned off);
    longint t1, t2;
    longint unsigned ms, t2m;
    t1 = (s * d) / (c * 64);
    ms = longint'(abs64(s));
    t2m = (ms * off + (64'd1 << 37)) >> 38;
    t2 = s < 0 ? -longint'(t2m) : longint'(t2m);
    return clamp32(t1 + t2);
  endfunction

  // advance the pose by one set of readings
  function automatic pose_t update_pose(longint l, longint r, longint b, longint gt);
    longint lt, rt, bt, g, odom, dg, nh, c, db, dr, lx, ly, sh, chh, sa, ca, gx, gy;
    pose_t p;
    lt = wheel_travel(l);
    rt = wheel_travel(r);
    bt = wheel_travel(b);
    g = gyro_angle(gt);
    odom = clamp32(start_hdg + wheel_turn(lt - rt));
    dg = g - odom;
    if (longint'(abs64(dg)) > longint'(thresh_q)) nh = clamp32(hdg + (g - prev_gyro));
    else nh = odom;
    c = nh - hdg;
    db = clamp32(bt - prev_back);
    dr = clamp32(rt - prev_right);
    if (c == 0) begin
      lx = db;
      ly = dr;
    end else begin
      sin_cos(c / 2, sh, chh);
      lx = arc_chord(2 * sh, db, c, back_q);
      ly = arc_chord(2 * sh, dr, c, side_q);
    end
    sin_cos(hdg + c / 2, sa, ca);
    gx = (lx * ca + ly * sa + (64'sd1 <<< 29)) >>> 30;
    gy = (ly * ca - lx * sa + (64'sd1 <<< 29)) >>> 30;
    px = clamp32(px + gx);
    py = clamp32(py + gy);
    hdg = nh;
    prev_gyro = g;
    prev_right = rt;
    prev_back = bt;
    p.pos_x = px[31:0];
    p.pos_y = py[31:0];
    p.heading = hdg[31:0];
    return p;
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    fails++;
    $display("%0t mismatch %s: expected %h got %h", $time, what, want, got);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_TRK_RADIUS: radius_q = 64'(val);
      CFG_SIDE_OFFSET: side_q = 64'(val);
      CFG_BACK_OFFSET: back_q = 64'(val);
      CFG_GYRO_THRESHOLD: thresh_q = 64'(val[30:0]);
      CFG_START_HEADING: start_hdg = longint'($signed(val));
      default: ;
    endcase
  endtask

  // offer one word, predict its pose once accepted
  task automatic send_word(longint l, longint r, longint b, longint g, bit typed, pose_t want);
    pose_t p;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {g[23:0], b[23:0], r[23:0], l[23:0]};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    p = update_pose(l, r, b, g);
    pending_poses.push_back(typed ? want : p);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_reg(logic [31:0] lo, logic [31:0] hi, logic [31:0] typ);
    int k;
    k = $urandom_range(5);
    if (k == 0) return lo;
    if (k == 1) return hi;
    if (k == 2) return $urandom;
    return typ + ($urandom_range(255) << 16) - (32'd128 << 16);
  endfunction

  function automatic longint wrap24(longint v);
    return (v > 8388607 || v < -8388608) ? 0 : v;
  endfunction

  // mostly plausible drives with small steps and a matching gyro, some pure noise
  task automatic send_random();
    longint g;
    if ($urandom_range(99) < 15) begin
      send_word(longint'($signed($urandom_range(24'hffffff) << 8)) >>> 8,
                longint'($signed($urandom << 8)) >>> 8,
                longint'($signed($urandom << 8)) >>> 8,
                longint'($signed($urandom << 8)) >>> 8, 1'b0, '0);
    end else begin
      walk_l = wrap24(walk_l + $urandom_range(400) - 200);
      walk_r = wrap24(walk_r + $urandom_range(400) - 200);
      walk_b = wrap24(walk_b + $urandom_range(400) - 200);
      if (side_q != 0)
        g = ((walk_l - walk_r) * longint'(radius_q) * 10) / (2 * longint'(side_q));
      else
        g = 0;
      g = g + ((start_hdg * 573) >>> 24) + $urandom_range(6) - 3;
      if ($urandom_range(9) == 0) g = g + $urandom_range(2000) - 1000;
      send_word(walk_l, walk_r, walk_b, wrap24(g), 1'b0, '0);
    end
  endtask

  // receive side: random stalls, one long hold on request
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_poses.size() == 0) begin
        report("unexpected word", 32'd0, m_axis_tdata[31:0]);
      end else begin
        pose_t want, got;
        want = pending_poses.pop_front();
        got.pos_x = m_axis_tdata[31:0];
        got.pos_y = m_axis_tdata[63:32];
        got.heading = m_axis_tdata[95:64];
        if (got.pos_x !== want.pos_x) report("pos_x", want.pos_x, got.pos_x);
        if (got.pos_y !== want.pos_y) report("pos_y", want.pos_y, got.pos_y);
        if (got.heading !== want.heading) report("heading", want.heading, got.heading);
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= recv_stall;
    end
  end

  initial begin
    #(64'd100_000_000);
    $display("three_wheel_odometry_update_test: FAIL");
    $finish;
  end

  initial begin
    row_t rows [$];
    int   idle_mode [4][2];
    idle_mode = '{'{0, 0}, '{78, 0}, '{0, 78}, '{22, 22}};

    // predictor at reset
    radius_q = 64'(RST_TRK_RADIUS);
    side_q = 64'(RST_SIDE_OFFSET);
    back_q = 64'(RST_BACK_OFFSET);
    thresh_q = 64'(RST_GYRO_THRESHOLD);
    start_hdg = longint'(RST_START_HEADING);
    hdg = start_hdg;
    px = 0; py = 0; prev_gyro = 0; prev_right = 0; prev_back = 0;
    walk_l = 0; walk_r = 0; walk_b = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: first item from rest, extremes, heading changes, gyro takeover
    rows = '{
      '{0, 0, 0, 0, 1'b1, '{32'sd0, 32'sd0, 32'sd0}},
      '{0, 0, 0, 0, 1'b1, '{32'sd0, 32'sd0, 32'sd0}},
      '{100, 100, 50, 0, 1'b0, '0},
      '{200, 150, 60, 10, 1'b0, '0},
      '{150, 200, 40, -5, 1'b0, '0},
      '{150, 200, 40, 900, 1'b0, '0},
      '{150, 200, 40, -900, 1'b0, '0},
      '{8388607, 8388607, 8388607, 8388607, 1'b0, '0},
      '{-8388608, -8388608, -8388608, -8388608, 1'b0, '0},
      '{8388607, -8388608, 0, 0, 1'b0, '0},
      '{-8388608, 8388607, 8388607, -8388608, 1'b0, '0},
      '{0, 0, 0, 0, 1'b0, '0},
      '{1, -1, 1, -1, 1'b0, '0},
      '{-1, 1, -1, 1, 1'b0, '0},
      '{5592405, -5592406, -5592406, 5592405, 1'b0, '0}
    };
    foreach (rows[i])
      send_word(rows[i].left, rows[i].right, rows[i].back, rows[i].gyro,
                rows[i].typed, rows[i].pose);
    drain();

    // zero side offset and a start heading written after reset
    write_reg(CFG_SIDE_OFFSET, 32'd0);
    write_reg(CFG_START_HEADING, 32'h8000_0000);
    cfg_we <= 1'b0;
    send_word(300, 100, 0, 5, 1'b0, '0);
    send_word(300, 300, 0, 5, 1'b0, '0);
    drain();
    write_reg(CFG_START_HEADING, 32'h7fff_ffff);
    write_reg(CFG_TRK_RADIUS, 32'hffff_ffff);
    write_reg(CFG_SIDE_OFFSET, 32'd1);
    write_reg(CFG_GYRO_THRESHOLD, 32'h7fff_ffff);
    write_reg(3'd6, 32'hdead_beef);
    cfg_we <= 1'b0;
    send_word(8388607, -8388608, 8388607, 0, 1'b0, '0);
    send_word(-1, 1, 0, 0, 1'b0, '0);
    drain();

    // random phases, each with its own settings and idle pattern
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_TRK_RADIUS, pick_reg(32'd0, 32'hffff_ffff, RST_TRK_RADIUS));
      write_reg(CFG_SIDE_OFFSET, pick_reg(32'd1, 32'hffff_ffff, RST_SIDE_OFFSET));
      write_reg(CFG_BACK_OFFSET, pick_reg(32'd0, 32'hffff_ffff, RST_BACK_OFFSET));
      write_reg(CFG_GYRO_THRESHOLD,
                pick_reg(32'd0, 32'h7fff_ffff, {1'b0, RST_GYRO_THRESHOLD}) & 32'h7fff_ffff);
      write_reg(CFG_START_HEADING, pick_reg(32'h8000_0000, 32'h7fff_ffff, 32'd0));
      if (ph == 7) write_reg(3'd5, $urandom);
      cfg_we <= 1'b0;
      send_idle = idle_mode[ph % 4][0];
      recv_stall = idle_mode[ph % 4][1];
      if (ph == 2) hold_req = 1'b1;
      repeat (215) send_random();
      drain();
    end

    send_idle = 0;
    recv_stall = 0;
    repeat (250) @(posedge clk);
    if (fails == 0) begin
      $display("three_wheel_odometry_update_test: PASS");
    end else begin
      $display("three_wheel_odometry_update_test: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/otw_pkg.sv
src/otw_div.sv
src/otw_cordic.sv
src/otw_dp.sv
src/otw_ctrl.sv
src/three_wheel_odometry_update.sv
tb/three_wheel_odometry_update_test.sv
